// ===== hdl/csl_pkg.sv =====
// Shared types and constants for the letter counting sort block.
package csl_pkg;

    localparam int CSL_MAX_LEN     = 64;
    localparam int CSL_ALPHABET    = 26;
    localparam int CSL_QUEUE_DEPTH = 4;

    localparam int CSL_LETTER_W    = 7;
    localparam int CSL_CNT_W       = 7;
    localparam int CSL_IDX_W       = 5;
    localparam int CSL_FIRST_CODE  = 65;

    typedef struct packed {
        logic                 keep;
        logic [CSL_IDX_W-1:0] idx;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic emitting;
    } t_back_stat;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

// ===== hdl/csl_front.sv =====
// Front end: input handshake and letter classification.
module csl_front
    import csl_pkg::*;
#(
    parameter int ALPHABET_SIZE = CSL_ALPHABET
) (
    input  logic                    i_in_valid,
    input  logic [CSL_LETTER_W-1:0] i_letter,
    input  logic                    i_is_final,
    input  t_q_stat                 i_q_stat,
    output logic                    o_in_stall,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    logic [CSL_LETTER_W-1:0] diff;
    logic                    in_range;

    assign diff     = i_letter - CSL_LETTER_W'(CSL_FIRST_CODE);
    assign in_range = (i_letter >= CSL_LETTER_W'(CSL_FIRST_CODE)) &&
                      (diff < CSL_LETTER_W'(ALPHABET_SIZE));

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_cmd.keep = in_range;
        o_cmd.idx  = diff[CSL_IDX_W-1:0];
        o_cmd.last = i_is_final;
    end

endmodule

// ===== hdl/csl_queue.sv =====
// Short command queue between front and back ends.
module csl_queue
    import csl_pkg::*;
#(
    parameter int DEPTH = CSL_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== hdl/csl_back.sv =====
// Back end: letter counts, sorted emission walk and output register.
module csl_back
    import csl_pkg::*;
#(
    parameter int MAX_LEN       = CSL_MAX_LEN,
    parameter int ALPHABET_SIZE = CSL_ALPHABET
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  t_q_stat                 i_q_stat,
    output logic                    o_pop,
    output t_back_stat              o_stat,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [CSL_LETTER_W-1:0] o_sorted_letter,
    output logic                    o_final_out
);

    localparam int IW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int TW = $clog2(MAX_LEN + 1);

    t_state                  r_state, n_state;
    logic [CSL_CNT_W-1:0]    r_cnt [ALPHABET_SIZE];
    logic [TW-1:0]           r_total, n_total;
    logic [IW-1:0]           r_walk;
    logic                    r_out_valid;
    logic [CSL_LETTER_W-1:0] r_out_letter;
    logic                    r_out_final;

    logic [IW-1:0]           rd_idx;
    logic [CSL_CNT_W-1:0]    cur;
    logic                    out_free;
    logic                    do_inc;
    logic                    do_emit;
    logic                    do_step;

    assign rd_idx   = (r_state == ST_EMIT) ? r_walk : i_cmd.idx[IW-1:0];
    assign cur      = r_cnt[rd_idx];
    assign out_free = !r_out_valid || !i_out_stall;

    // output decode
    always_comb begin
        o_pop   = 1'b0;
        do_inc  = 1'b0;
        do_emit = 1'b0;
        do_step = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_pop  = !i_q_stat.empty;
                do_inc = o_pop && i_cmd.keep && (r_total < TW'(MAX_LEN));
            end
            ST_EMIT: begin
                do_emit = (cur != '0) && out_free;
                do_step = (cur == '0);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_total = r_total;
        if (do_inc) begin
            n_total = r_total + TW'(1);
        end else if (do_emit) begin
            n_total = r_total - TW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (o_pop && i_cmd.last && (n_total != '0)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (do_emit && (r_total == TW'(1))) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_total     <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ALPHABET_SIZE; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (do_inc) begin
                r_cnt[rd_idx] <= cur + CSL_CNT_W'(1);
            end else if (do_emit) begin
                r_cnt[rd_idx] <= cur - CSL_CNT_W'(1);
            end
            if (r_state == ST_LOAD) begin
                r_walk <= '0;
            end else if (do_step) begin
                r_walk <= r_walk + IW'(1);
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_letter <= CSL_LETTER_W'(CSL_FIRST_CODE) + CSL_LETTER_W'(r_walk);
            r_out_final  <= (r_total == TW'(1));
        end
    end

    assign o_stat.emitting = (r_state == ST_EMIT);
    assign o_out_valid     = r_out_valid;
    assign o_sorted_letter = r_out_letter;
    assign o_final_out     = r_out_final;

endmodule

// ===== hdl/counting_sort_letters_unit.sv =====
// A letter is counted at the queue head in the load state; 1 letter/cycle, held while emitting.
// After the final letter, the emission walk steps past each letter code with a zero count
// and sends the sorted letters through the output register, holding while the output stalls.
// Reset: synchronous, active low; clears counts, total, queue pointers, FSM and output valid.
// Input is stalled only while the 4-entry command queue is full.
module counting_sort_letters_unit
    import csl_pkg::*;
#(
    parameter int MAX_LEN       = CSL_MAX_LEN,
    parameter int ALPHABET_SIZE = CSL_ALPHABET,
    parameter int QUEUE_DEPTH   = CSL_QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel: one letter per transfer
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CSL_LETTER_W-1:0] i_letter,
    input  logic                    i_is_final,
    // output channel: one sorted letter per transfer
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [CSL_LETTER_W-1:0] o_sorted_letter,
    output logic                    o_final_out
);

    t_cmd       front_cmd;
    t_cmd       head_cmd;
    t_q_stat    q_stat;
    t_back_stat back_stat;
    logic       push;
    logic       pop;

    // Classify each letter and push it into the queue.
    csl_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_letter   (i_letter),
        .i_is_final (i_is_final),
        .i_q_stat   (q_stat),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // Decouple input acceptance from the emission walk.
    csl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // Count letters; on the final one, if any are stored, walk the counts and drain in order.
    csl_back #(
        .MAX_LEN       (MAX_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_stat          (back_stat),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sorted_letter (o_sorted_letter),
        .o_final_out     (o_final_out)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(back_stat.emitting))
        else $error("result appeared outside the emission walk");
`endif

endmodule

// ===== sim/counting_sort_letters_unit_tb.sv =====
// Self-checking testbench for the letter counting sort unit.
`timescale 1ns / 100ps

module counting_sort_letters_unit_tb;
    import csl_pkg::*;

    // Give up well past the slowest legal run.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles to watch for stray results once nothing is pending.
    localparam int SETTLE_CYCLES = 100;
    localparam int LAST_CODE     = (1 << CSL_LETTER_W) - 1;
    localparam int RANDOM_GOAL   = 340;

    typedef struct packed {
        logic [CSL_LETTER_W-1:0] letter;
        logic                    last;
    } t_sorted_item;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic                    o_in_stall;
    logic [CSL_LETTER_W-1:0] i_letter        = '0;
    logic                    i_is_final      = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall     = 1'b0;
    logic [CSL_LETTER_W-1:0] o_sorted_letter;
    logic                    o_final_out;

    // Predictor state: one occurrence count per letter plus the stored total.
    logic [CSL_CNT_W-1:0]    tally [CSL_ALPHABET];
    logic [CSL_CNT_W-1:0]    stored_total;
    // Sorted letters still owed by the block, oldest first.
    t_sorted_item            sorted_q[$];

    // Idle shaping: upper bound of the per-item wait on each side.
    int send_gap_max = 0;
    int recv_gap_max = 0;
    // Receiver wait for the current result, and a long forced hold-off.
    int stall_left   = 0;
    int hold_left    = 0;

    int cycle_count        = 0;
    int error_count        = 0;
    int letters_sent       = 0;
    int strings_closed     = 0;
    int results_checked    = 0;
    int letters_dropped    = 0;
    int input_stall_cycles = 0;

    counting_sort_letters_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_letter       (i_letter),
        .i_is_final     (i_is_final),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_letter(o_sorted_letter),
        .o_final_out    (o_final_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Count one accepted letter and, on the final flag, queue the sorted string.
    task automatic count_and_sort(input logic [CSL_LETTER_W-1:0] code, input logic fin);
        int           idx;
        int           sent;
        t_sorted_item item;
        if (code >= CSL_FIRST_CODE && code < CSL_FIRST_CODE + CSL_ALPHABET) begin
            if (stored_total < CSL_MAX_LEN) begin
                idx = code - CSL_FIRST_CODE;
                tally[idx]++;
                stored_total++;
            end else begin
                letters_dropped++;
            end
        end
        if (fin) begin
            // Walk the counts from A upward; flag the letter that empties the total.
            sent = 0;
            for (int k = 0; k < CSL_ALPHABET; k++) begin
                for (int n = 0; n < tally[k]; n++) begin
                    sent++;
                    item.letter = CSL_LETTER_W'(CSL_FIRST_CODE + k);
                    item.last   = (sent == stored_total);
                    sorted_q.push_back(item);
                end
            end
            strings_closed++;
            foreach (tally[k]) tally[k] = '0;
            stored_total = '0;
        end
    endtask

    // Offer one letter after a random idle gap; return at the accepting edge.
    task automatic send_letter(input logic [CSL_LETTER_W-1:0] code, input logic fin);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_letter   = code;
        i_is_final = fin;
        do @(posedge i_clk); while (o_in_stall);
        count_and_sort(code, fin);
        letters_sent++;
    endtask

    // Drop valid and hold the sender until every owed letter has arrived.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CSL_LETTER_W-1:0] ltr(input int ofs);
        return CSL_LETTER_W'(CSL_FIRST_CODE + ofs);
    endfunction

    function automatic logic [CSL_LETTER_W-1:0] random_letter();
        return ltr($urandom_range(0, CSL_ALPHABET - 1));
    endfunction

    // Any 7-bit code outside A..Z, below or above the alphabet.
    function automatic logic [CSL_LETTER_W-1:0] noise_code();
        if ($urandom_range(0, 1) == 0)
            return CSL_LETTER_W'($urandom_range(0, CSL_FIRST_CODE - 1));
        return CSL_LETTER_W'($urandom_range(CSL_FIRST_CODE + CSL_ALPHABET, LAST_CODE));
    endfunction

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 12;
        endcase
    endfunction

    // Receiver: stall for the drawn wait after each transfer, or for a forced hold.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Checker: compare each output transfer with the oldest owed letter.
    always @(posedge i_clk) begin : check_results
        t_sorted_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall)
                input_stall_cycles++;
            if (o_out_valid && !i_out_stall) begin
                if (sorted_q.size() == 0) begin
                    $error("unexpected sorted letter %0d with nothing pending",
                           o_sorted_letter);
                    error_count++;
                end else begin
                    want = sorted_q.pop_front();
                    if (o_sorted_letter !== want.letter) begin
                        $error("sorted_letter: expected %0d, got %0d",
                               want.letter, o_sorted_letter);
                        error_count++;
                    end
                    if (o_final_out !== want.last) begin
                        $error("final_out: expected %0d, got %0d",
                               want.last, o_final_out);
                        error_count++;
                    end
                end
                results_checked++;
                stall_left = $urandom_range(0, recv_gap_max);
            end
        end
    end

    // Single letters at both ends of the alphabet, then a short mixed string.
    task automatic test_plain_strings();
        send_gap_max = 0;
        recv_gap_max = 0;
        send_letter(ltr(CSL_ALPHABET - 1), 1'b1);
        send_letter(ltr(0), 1'b1);
        send_letter(ltr(1), 1'b0);
        send_letter(ltr(0), 1'b0);
        send_letter(ltr(CSL_ALPHABET - 1), 1'b0);
        send_letter(ltr(0), 1'b1);
        wait_for_drain();
    endtask

    // Codes outside A..Z are skipped; the all-zero and all-one codes toggle every bit.
    task automatic test_out_of_alphabet();
        send_gap_max = 2;
        recv_gap_max = 2;
        send_letter(CSL_LETTER_W'(LAST_CODE), 1'b0);
        send_letter(ltr(12), 1'b0);
        send_letter(CSL_LETTER_W'(CSL_FIRST_CODE - 1), 1'b0);
        send_letter('0, 1'b0);
        send_letter(CSL_LETTER_W'(CSL_FIRST_CODE + CSL_ALPHABET), 1'b1);
        // A string closed by a skipped code still sorts what it holds.
        send_letter(ltr(2), 1'b0);
        send_letter(CSL_LETTER_W'(95), 1'b1);
        wait_for_drain();
    endtask

    // A final flag with nothing stored yields no letters but still clears.
    task automatic test_empty_string();
        send_gap_max = 1;
        recv_gap_max = 0;
        send_letter('0, 1'b1);
        send_letter(CSL_LETTER_W'(CSL_FIRST_CODE + CSL_ALPHABET), 1'b1);
        send_letter(ltr(7), 1'b0);
        send_letter(ltr(7), 1'b1);
        wait_for_drain();
    endtask

    // Overflow the 64-letter store: one letter only, then a random string whose
    // closing letter is itself dropped.
    task automatic test_capacity();
        send_gap_max = 0;
        recv_gap_max = 1;
        for (int i = 0; i < CSL_MAX_LEN + 2; i++)
            send_letter(ltr(10), i == CSL_MAX_LEN + 1);
        wait_for_drain();
        send_gap_max = 3;
        recv_gap_max = 0;
        for (int i = 0; i < CSL_MAX_LEN + 6; i++)
            send_letter(random_letter(), i == CSL_MAX_LEN + 5);
        wait_for_drain();
    endtask

    // Hold the receiver for a long stretch while the sender keeps offering, so the
    // command queue fills and the input stalls.
    task automatic test_backpressure();
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_left    = 300;
        for (int i = 0; i < 6; i++)
            send_letter(random_letter(), i == 5);
        for (int i = 0; i < 12; i++)
            send_letter(random_letter(), 1'b0);
        send_letter(random_letter(), 1'b1);
        wait_for_drain();
    endtask

    // Random strings: mostly clean letters, some noise, empties and overflows.
    task automatic test_random_strings(input int letter_goal);
        int mode;
        int len;
        int strings;
        strings = 0;
        while (letters_sent < letter_goal) begin
            mode         = $urandom_range(0, 19);
            send_gap_max = pick_gap_max();
            recv_gap_max = pick_gap_max();
            if (mode < 15) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_letter(random_letter(), i == len - 1);
            end else if (mode < 17) begin
                // Interleave skipped codes with real letters.
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_letter(($urandom_range(0, 9) < 3) ? noise_code() : random_letter(),
                                i == len - 1);
            end else if (mode < 19) begin
                // Close on a skipped code, sometimes with nothing stored.
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    send_letter(random_letter(), 1'b0);
                send_letter(noise_code(), 1'b1);
            end else begin
                len = $urandom_range(40, CSL_MAX_LEN + 8);
                for (int i = 0; i < len; i++)
                    send_letter(random_letter(), i == len - 1);
            end
            strings++;
            // Pause the sender now and then until the block has drained.
            if (strings % 6 == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        foreach (tally[k]) tally[k] = '0;
        stored_total = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_strings();
        test_out_of_alphabet();
        test_empty_string();
        test_capacity();
        test_backpressure();
        test_random_strings(RANDOM_GOAL);

        // Watch for stray letters past the longest drain.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sorted %0d strings from %0d letters, %0d sorted letters checked.",
                 strings_closed, letters_sent, results_checked);
        $display("Letters dropped at capacity: %0d; cycles with input stalled: %0d.",
                 letters_dropped, input_stall_cycles);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
